@@ rtl/hfetbd_pkg.sv @@
// Shared types, constants and helpers for the track bitstream decoder.
// No dependencies; imported by every module in rtl/.
package hfetbd_pkg;

  // Half-block geometry: each 2*HALF_BLOCK bytes hold one half per side
  localparam int HALF_BLOCK = 256;
  localparam int HALF_W     = $clog2(HALF_BLOCK);
  localparam int POS_W      = HALF_W + 1;

  // Command queue depth between front and back
  localparam int Q_DEPTH = 2;
  localparam int Q_PTR_W = $clog2(Q_DEPTH);
  localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

  // Opcodes, in decoded (bit-reversed) order
  localparam logic [7:0] OP_NOP      = 8'hF0;
  localparam logic [7:0] OP_SETINDEX = 8'hF1;
  localparam logic [7:0] OP_SETRATE  = 8'hF2;
  localparam logic [7:0] OP_SKIPBITS = 8'hF3;
  localparam logic [7:0] OP_RAND     = 8'hF4;
  localparam logic [3:0] OP_PREFIX   = 4'hF;

  // Track encodings
  localparam logic [7:0] ENC_ISO_FM = 8'h02;

  // Configuration register indexes
  localparam logic [1:0] CFG_V3   = 2'd0;
  localparam logic [1:0] CFG_ENC  = 2'd1;
  localparam logic [1:0] CFG_SIDE = 2'd2;

  typedef enum logic [1:0] {
    ST_DATA   = 2'd0,
    ST_BAD_OP = 2'd1,
    ST_CUT_OP = 2'd2
  } status_t;

  // One queued command: either a byte of bits to gather or a status word
  typedef struct packed {
    logic       is_bits;
    logic       clr;      // restart bit assembly before this command
    logic [7:0] data;
    logic [3:0] skip;     // leading bits to drop, 8 drops the lot
    status_t    st;
  } cmd_t;

  function automatic logic [7:0] flip8(input logic [7:0] v);
    logic [7:0] r;
    for (int i = 0; i < 8; i++) begin
      r[7 - i] = v[i];
    end
    return r;
  endfunction

endpackage

@@ rtl/hfetbd_front.sv @@
// Front end: position tracking, half selection and opcode parsing.
// Depends on hfetbd_pkg; pushes commands into hfetbd_queue.
module hfetbd_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [7:0]          in_raw_byte,
  input  logic [7:0]          in_random_fill,
  input  logic                in_track_start,
  input  logic                v3_en,
  input  logic                side_sel,
  input  logic                q_full,
  output logic                push,
  output hfetbd_pkg::cmd_t    cmd
);
  import hfetbd_pkg::*;

  typedef enum logic [1:0] {
    PH_NORMAL = 2'd0,
    PH_RATE   = 2'd1,
    PH_COUNT  = 2'd2,
    PH_TARGET = 2'd3
  } phase_t;

  logic [POS_W-1:0] pos_r, pos_nxt;
  phase_t           phase_r, phase_nxt;
  logic [7:0]       pend_r, pend_nxt;
  logic             halted_r, halted_nxt;
  logic             clr_r, clr_nxt;
  logic             push_nxt;
  cmd_t             cmd_nxt;

  logic             accept;
  logic [POS_W-1:0] pos;
  logic [HALF_W-1:0] off;
  logic             last;
  logic [7:0]       b;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;
  assign push     = push_nxt;
  assign cmd      = cmd_nxt;

  assign pos  = in_track_start ? '0 : pos_r;
  assign off  = pos[HALF_W-1:0];
  assign last = (off == HALF_W'(HALF_BLOCK - 1));
  assign b    = flip8(in_raw_byte);

  // Classify the word and work out the parser's next state
  always_comb begin
    pos_nxt    = pos_r;
    phase_nxt  = phase_r;
    pend_nxt   = pend_r;
    halted_nxt = halted_r;
    clr_nxt    = clr_r;
    push_nxt   = 1'b0;
    cmd_nxt    = '{is_bits: 1'b1, clr: 1'b0, data: b, skip: 4'd0, st: ST_DATA};
    if (accept) begin
      pos_nxt = pos + 1'b1;  // wraps at the block end
      if (off == '0) begin
        phase_nxt  = PH_NORMAL;
        pend_nxt   = '0;
        halted_nxt = 1'b0;
        clr_nxt    = 1'b1;
      end
      if (pos[POS_W-1] == side_sel && !halted_nxt) begin
        unique case (phase_nxt)
          PH_RATE: begin
            phase_nxt = PH_NORMAL;
          end
          PH_COUNT: begin
            phase_nxt = PH_NORMAL;
            if (last) begin
              push_nxt       = 1'b1;
              cmd_nxt.is_bits = 1'b0;
              cmd_nxt.st     = ST_CUT_OP;
            end else begin
              pend_nxt  = b;
              phase_nxt = PH_TARGET;
            end
          end
          PH_TARGET: begin
            push_nxt     = 1'b1;
            cmd_nxt.skip = (|pend_nxt[7:3]) ? 4'd8 : pend_nxt[3:0];
            pend_nxt     = '0;
            phase_nxt    = PH_NORMAL;
          end
          default: begin
            if (v3_en && b[7:4] == OP_PREFIX) begin
              unique case (b)
                OP_NOP, OP_SETINDEX: ;
                OP_SETRATE, OP_SKIPBITS: begin
                  if (last) begin
                    push_nxt        = 1'b1;
                    cmd_nxt.is_bits = 1'b0;
                    cmd_nxt.st      = ST_CUT_OP;
                  end else begin
                    phase_nxt = (b == OP_SETRATE) ? PH_RATE : PH_COUNT;
                  end
                end
                OP_RAND: begin
                  push_nxt     = 1'b1;
                  cmd_nxt.data = in_random_fill;
                end
                default: begin
                  halted_nxt      = 1'b1;
                  push_nxt        = 1'b1;
                  cmd_nxt.is_bits = 1'b0;
                  cmd_nxt.st      = ST_BAD_OP;
                end
              endcase
            end else begin
              push_nxt = 1'b1;
            end
          end
        endcase
      end
      // pending restart rides on the next command out
      cmd_nxt.clr = clr_nxt;
      if (push_nxt) begin
        clr_nxt = 1'b0;
      end
    end
  end

  // Parser state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r    <= '0;
      phase_r  <= PH_NORMAL;
      pend_r   <= '0;
      halted_r <= 1'b0;
      clr_r    <= 1'b1;
    end else begin
      pos_r    <= pos_nxt;
      phase_r  <= phase_nxt;
      pend_r   <= pend_nxt;
      halted_r <= halted_nxt;
      clr_r    <= clr_nxt;
    end
  end

  // Pending skip only exists while a target byte is awaited
  a_pend_phase: assert property (@(posedge clk) disable iff (!rst_n)
    (pend_r != '0) |-> (phase_r == PH_TARGET))
    else $error("pending skip held outside target phase");

  // Nothing is pushed without a word being taken
  a_push_accept: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> accept)
    else $error("command pushed without an accepted word");

  // Halted half leaves the parser in normal phase
  a_halt_phase: assert property (@(posedge clk) disable iff (!rst_n)
    halted_r |-> (phase_r == PH_NORMAL))
    else $error("parser halted mid-operand");

endmodule

@@ rtl/hfetbd_queue.sv @@
// Short command queue decoupling the parser from the bit assembler.
// Depends on hfetbd_pkg for cmd_t and depth constants.
module hfetbd_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  hfetbd_pkg::cmd_t wr_cmd,
  output logic             full,
  input  logic             pop,
  output logic             not_empty,
  output hfetbd_pkg::cmd_t rd_cmd
);
  import hfetbd_pkg::*;

  cmd_t               mem_r [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [Q_CNT_W-1:0] cnt_r;
  logic               do_push, do_pop;

  assign full      = (cnt_r == Q_CNT_W'(Q_DEPTH));
  assign not_empty = (cnt_r != '0);
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;
  assign rd_cmd    = mem_r[rd_ptr_r];

  // Storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wr_cmd;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      cnt_r <= cnt_r + Q_CNT_W'(do_push) - Q_CNT_W'(do_pop);
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= Q_CNT_W'(Q_DEPTH))
    else $error("queue count over depth");

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(push && full))
    else $error("push into full queue");

  a_pop_count: assert property (@(posedge clk) disable iff (!rst_n)
    (do_pop && !do_push) |=> (cnt_r == $past(cnt_r) - 1'b1))
    else $error("queue count lost a pop");

endmodule

@@ rtl/hfetbd_back.sv @@
// Back end: gathers kept bits into bytes and holds the result word.
// Depends on hfetbd_pkg; pops commands from hfetbd_queue.
module hfetbd_back (
  input  logic             clk,
  input  logic             rst_n,
  input  logic [7:0]       enc,
  input  logic             q_not_empty,
  input  hfetbd_pkg::cmd_t q_cmd,
  output logic             pop,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [7:0]       out_decoded_byte,
  output logic [1:0]       out_status
);
  import hfetbd_pkg::*;

  logic       keep_r, keep_nxt;
  logic [2:0] gath_r, gath_nxt;
  logic [7:0] asm_r, asm_nxt;
  logic       ov_r, ov_nxt;
  logic [7:0] od_r, od_nxt;
  status_t    os_r, os_nxt;

  logic       emit;
  logic [7:0] emit_val;

  assign pop              = q_not_empty && (!ov_r || out_ready);
  assign out_valid        = ov_r;
  assign out_decoded_byte = od_r;
  assign out_status       = os_r;

  // Walk the eight bits of a command, most significant first
  always_comb begin
    logic       k;
    logic [3:0] g;
    logic [7:0] a;
    k        = keep_r;
    g        = {1'b0, gath_r};
    a        = asm_r;
    emit     = 1'b0;
    emit_val = '0;
    if (q_cmd.clr) begin
      k = 1'b1;
      g = '0;
      a = '0;
    end
    if (q_cmd.is_bits) begin
      for (int i = 0; i < 8; i++) begin
        if (4'(i) >= q_cmd.skip) begin
          if (k) begin
            a = {q_cmd.data[7 - i], a[7:1]};
            g = g + 1'b1;
            if (g[3]) begin
              emit     = 1'b1;
              emit_val = a;
              a        = '0;
              g        = '0;
            end
          end
          k = (enc == ENC_ISO_FM) ? !k : 1'b1;
        end
      end
    end
    keep_nxt = k;
    gath_nxt = g[2:0];
    asm_nxt  = a;
  end

  // Output register next value
  always_comb begin
    ov_nxt = ov_r && !out_ready;
    od_nxt = od_r;
    os_nxt = os_r;
    if (pop) begin
      if (!q_cmd.is_bits) begin
        ov_nxt = 1'b1;
        od_nxt = '0;
        os_nxt = q_cmd.st;
      end else if (emit) begin
        ov_nxt = 1'b1;
        od_nxt = emit_val;
        os_nxt = ST_DATA;
      end
    end
  end

  // Assembly state and output word
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      keep_r <= 1'b1;
      gath_r <= '0;
      asm_r  <= '0;
      ov_r   <= 1'b0;
    end else begin
      if (pop) begin
        keep_r <= keep_nxt;
        gath_r <= gath_nxt;
        asm_r  <= asm_nxt;
      end
      ov_r <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    od_r <= od_nxt;
    os_r <= os_nxt;
  end

  // Error words never carry data
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (ov_r && os_r != ST_DATA) |-> (od_r == '0))
    else $error("status word with nonzero data");

  // A held word is not replaced while the sink stalls
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (ov_r && !out_ready) |=> (ov_r && $stable(od_r) && $stable(os_r)))
    else $error("result overwritten under stall");

  // Without ISO FM every gathered bit leaves the keep flag set
  a_keep: assert property (@(posedge clk) disable iff (!rst_n)
    (pop && q_cmd.is_bits && q_cmd.skip != 4'd8 && enc != ENC_ISO_FM) |=> keep_r)
    else $error("bit dropped outside FM");

endmodule

@@ rtl/hfe_track_bitstream_decoder_core.sv @@
// Track bitstream decoder: one side of an interleaved track to data bytes.
// Path: an accepted word is written into the command queue, then its result into the output register.
// Throughput: one word per cycle while the queue has room; the 2-deep command queue and the output
// register let the parser run on while a result waits to be taken.
// Reset (rst_n low, synchronous): config to 0, position 0, queue empty.
// Depends on hfetbd_pkg, hfetbd_front, hfetbd_queue, hfetbd_back.
module hfe_track_bitstream_decoder_core (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_raw_byte,
  input  logic [7:0] in_random_fill,
  input  logic       in_track_start,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_decoded_byte,
  output logic [1:0] out_status,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [1:0] cfg_index,
  input  logic [7:0] cfg_data
);
  import hfetbd_pkg::*;

  logic       v3_r;
  logic [7:0] enc_r;
  logic       side_r;

  logic       q_full, q_not_empty, push, pop;
  cmd_t       wr_cmd, rd_cmd;

  assign cfg_ready = 1'b1;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r   <= 1'b0;
      enc_r  <= '0;
      side_r <= 1'b0;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_V3:   v3_r   <= cfg_data[0];
        CFG_ENC:  enc_r  <= cfg_data;
        CFG_SIDE: side_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  hfetbd_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_raw_byte    (in_raw_byte),
    .in_random_fill (in_random_fill),
    .in_track_start (in_track_start),
    .v3_en          (v3_r),
    .side_sel       (side_r),
    .q_full         (q_full),
    .push           (push),
    .cmd            (wr_cmd)
  );

  hfetbd_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .wr_cmd    (wr_cmd),
    .full      (q_full),
    .pop       (pop),
    .not_empty (q_not_empty),
    .rd_cmd    (rd_cmd)
  );

  hfetbd_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .enc              (enc_r),
    .q_not_empty      (q_not_empty),
    .q_cmd            (rd_cmd),
    .pop              (pop),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_decoded_byte (out_decoded_byte),
    .out_status       (out_status)
  );

endmodule

@@ test/hfe_track_bitstream_decoder_core_test.sv @@
// Self-checking testbench for hfe_track_bitstream_decoder_core.
// A directed table, then random opcode-rich track words over several register settings.
// Depends on rtl/hfetbd_pkg.sv and the decoder core RTL.
`timescale 1ns / 1ps

module hfe_track_bitstream_decoder_core_test;
  import hfetbd_pkg::*;

  localparam int LAT_SLACK   = 6;    // cycles allowed after the last result
  localparam int HOLD_CYCLES = 60;   // long receiver hold-off
  localparam int PHASE_WORDS = 125;
  localparam int N_PHASES    = 8;

  typedef enum logic [1:0] {PH_DATA, PH_RATE_ARG, PH_SKIP_COUNT, PH_SKIP_TARGET} parse_ph_t;
  typedef enum logic [1:0] {RK_CFG, RK_WORD, RK_NOPS} row_kind_t;

  typedef struct packed {
    logic [7:0] data;
    status_t    st;
  } dec_res_t;

  typedef struct {
    row_kind_t  kind;
    logic [1:0] idx;
    logic [7:0] val;
    logic [7:0] raw;
    logic [7:0] fill;
    logic       start;
    int         reps;
    logic       typed;
    dec_res_t   t_res;
  } stim_row_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [7:0] in_raw_byte = 8'h00;
  logic [7:0] in_random_fill = 8'h00;
  logic       in_track_start = 1'b0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [7:0] out_decoded_byte;
  logic [1:0] out_status;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [1:0] cfg_index = 2'd0;
  logic [7:0] cfg_data = 8'h00;

  // Register shadows
  logic       sh_v3 = 1'b0;
  logic [7:0] sh_enc = 8'h00;
  logic       sh_side = 1'b0;

  // Decoder shadow state
  logic [POS_W-1:0] trk_pos = '0;
  parse_ph_t        ph_state = PH_DATA;
  logic [7:0]       skip_pend = 8'h00;
  logic             keep_bit = 1'b1;
  logic [3:0]       n_bits = 4'd0;
  logic [7:0]       shreg = 8'h00;
  logic             halted = 1'b0;

  dec_res_t  decoded_due[$];
  stim_row_t dir_rows[$];

  int errors = 0;
  int checked = 0;
  int words_sent = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_asked = 0;
  int hold_served = 0;
  int hold_left = 0;

  int ph_v3   [N_PHASES] = '{1, 1, 1, 1, 0, 1, 0, 1};
  int ph_enc  [N_PHASES] = '{0, 2, 0, 2, 255, 2, 2, 0};
  int ph_side [N_PHASES] = '{0, 0, 1, 1, 0, 0, 1, 0};
  int ph_mode [N_PHASES] = '{0, 1, 2, 3, 0, 2, 1, 3};

  hfe_track_bitstream_decoder_core uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_raw_byte      (in_raw_byte),
    .in_random_fill   (in_random_fill),
    .in_track_start   (in_track_start),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_decoded_byte (out_decoded_byte),
    .out_status       (out_status),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  // 8 ns clock
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic logic [7:0] rev8(input logic [7:0] v);
    logic [7:0] r;
    for (int i = 0; i < 8; i++) begin
      r[i] = v[7 - i];
    end
    return r;
  endfunction

  // Expected decoder behaviour for one accepted track word
  task automatic predict_track_word(input logic [7:0] raw, input logic [7:0] fill,
                                    input logic start, output logic got,
                                    output dec_res_t res);
    logic [POS_W-1:0]  cur;
    logic [HALF_W-1:0] off;
    logic [7:0]        b;
    logic [7:0]        skip_n;
    logic              at_last;
    logic              run_bits;
    got = 1'b0;
    res = '{data: 8'h00, st: ST_DATA};
    if (start) begin
      trk_pos = '0;
    end
    cur = trk_pos;
    off = cur[HALF_W-1:0];
    trk_pos = cur + 1'b1;   // wraps at two halves
    // every half restarts the decoder
    if (off == '0) begin
      ph_state  = PH_DATA;
      skip_pend = 8'h00;
      keep_bit  = 1'b1;
      n_bits    = 4'd0;
      shreg     = 8'h00;
      halted    = 1'b0;
    end
    if (cur[POS_W-1] != sh_side || halted) begin
      return;
    end
    b        = rev8(raw);
    at_last  = (off == {HALF_W{1'b1}});
    run_bits = 1'b1;
    skip_n   = 8'h00;
    case (ph_state)
      PH_RATE_ARG: begin
        ph_state = PH_DATA;
        run_bits = 1'b0;
      end
      PH_SKIP_COUNT: begin
        ph_state = PH_DATA;
        run_bits = 1'b0;
        if (at_last) begin
          got = 1'b1;
          res.st = ST_CUT_OP;
        end else begin
          skip_pend = b;
          ph_state  = PH_SKIP_TARGET;
        end
      end
      PH_SKIP_TARGET: begin
        skip_n    = skip_pend;
        skip_pend = 8'h00;
        ph_state  = PH_DATA;
      end
      default: begin
        if (sh_v3 && b[7:4] == OP_PREFIX) begin
          case (b)
            OP_NOP, OP_SETINDEX: run_bits = 1'b0;
            OP_SETRATE, OP_SKIPBITS: begin
              run_bits = 1'b0;
              if (at_last) begin
                got = 1'b1;
                res.st = ST_CUT_OP;
              end else begin
                ph_state = (b == OP_SETRATE) ? PH_RATE_ARG : PH_SKIP_COUNT;
              end
            end
            OP_RAND: b = fill;
            default: begin
              halted   = 1'b1;
              run_bits = 1'b0;
              got      = 1'b1;
              res.st   = ST_BAD_OP;
            end
          endcase
        end
      end
    endcase
    // gather bits, most significant first; dropped bits leave the FM pattern alone
    if (run_bits) begin
      for (int i = 7; i >= 0; i--) begin
        if (skip_n != 8'h00) begin
          skip_n = skip_n - 1'b1;
        end else begin
          if (keep_bit) begin
            shreg  = {b[i], shreg[7:1]};
            n_bits = n_bits + 1'b1;
            if (n_bits == 4'd8) begin
              got = 1'b1;
              res = '{data: shreg, st: ST_DATA};
              shreg  = 8'h00;
              n_bits = 4'd0;
            end
          end
          if (sh_enc == ENC_ISO_FM) begin
            keep_bit = ~keep_bit;
          end else begin
            keep_bit = 1'b1;
          end
        end
      end
    end
  endtask

  // Offer one word, honouring the sender idle rate; log what it should produce
  task automatic send_word(input logic [7:0] raw, input logic [7:0] fill, input logic start,
                           input logic typed, input dec_res_t t_res);
    logic     got;
    dec_res_t res;
    @(negedge clk);
    while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid       = 1'b1;
    in_raw_byte    = raw;
    in_random_fill = fill;
    in_track_start = start;
    @(posedge clk);
    while (!in_ready) begin
      @(posedge clk);
    end
    predict_track_word(raw, fill, start, got, res);
    words_sent++;
    if (typed) begin
      decoded_due.push_back(t_res);
    end else if (got) begin
      decoded_due.push_back(res);
    end
  endtask

  // Stop offering and wait for every outstanding result, plus latency slack
  task automatic wait_drained();
    @(negedge clk);
    in_valid = 1'b0;
    while (decoded_due.size() != 0) begin
      @(posedge clk);
    end
    repeat (LAT_SLACK) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [7:0] val);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = val;
    @(posedge clk);
    while (!cfg_ready) begin
      @(posedge clk);
    end
    case (idx)
      CFG_V3:   sh_v3 = val[0];
      CFG_ENC:  sh_enc = val;
      CFG_SIDE: sh_side = val[0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic tab_add(input row_kind_t kind, input logic [1:0] idx, input logic [7:0] val,
                         input logic [7:0] raw, input logic [7:0] fill, input logic start,
                         input int reps, input logic typed, input logic [7:0] t_data,
                         input status_t t_st);
    stim_row_t r;
    r.kind  = kind;
    r.idx   = idx;
    r.val   = val;
    r.raw   = raw;
    r.fill  = fill;
    r.start = start;
    r.reps  = reps;
    r.typed = typed;
    r.t_res = '{data: t_data, st: t_st};
    dir_rows.push_back(r);
  endtask

  // Receiver: random stalls, plus long hold-offs on request
  always @(negedge clk) begin
    if (hold_left == 0 && hold_served < hold_asked) begin
      hold_served++;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left != 0) begin
      out_ready = 1'b0;
      hold_left--;
    end else begin
      out_ready = ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Result checker
  always @(posedge clk) begin : result_check
    dec_res_t due;
    if (rst_n && out_valid && out_ready) begin
      if (decoded_due.size() == 0) begin
        $display("%0t: unexpected word: expected none, got byte %02h status %0d",
                 $time, out_decoded_byte, out_status);
        errors++;
      end else begin
        due = decoded_due.pop_front();
        checked++;
        if (out_decoded_byte !== due.data) begin
          $display("%0t: decoded_byte: expected %02h, got %02h",
                   $time, due.data, out_decoded_byte);
          errors++;
        end
        if (out_status !== due.st) begin
          $display("%0t: status: expected %0d, got %0d", $time, due.st, out_status);
          errors++;
        end
      end
    end
  end

  // Watchdog
  initial begin
    #8_000_000;
    $display("end of test: mismatches");
    $finish;
  end

  initial begin : stimulus
    logic [7:0] raw;
    logic [7:0] cnt;
    logic       count_due;
    int         sel;
    dec_res_t   none;
    none = '{data: 8'h00, st: ST_DATA};

    // Directed table; typed results only where obvious
    // plain bytes after reset pass through unchanged
    tab_add(RK_WORD, 0, 0, 8'h00, 8'h00, 1, 0, 1, 8'h00, ST_DATA);
    tab_add(RK_WORD, 0, 0, 8'hFF, 8'h00, 0, 0, 1, 8'hFF, ST_DATA);
    tab_add(RK_WORD, 0, 0, 8'hA5, 8'hFF, 0, 0, 1, 8'hA5, ST_DATA);
    tab_add(RK_WORD, 0, 0, rev8(OP_RAND), 8'h3C, 0, 0, 1, rev8(OP_RAND), ST_DATA);
    tab_add(RK_CFG, CFG_V3, 8'h01, 0, 0, 0, 0, 0, 0, ST_DATA);
    // every opcode
    tab_add(RK_WORD, 0, 0, rev8(OP_NOP), 8'h00, 1, 0, 0, 0, ST_DATA);
    tab_add(RK_WORD, 0, 0, rev8(OP_SETINDEX), 8'h00, 0, 0, 0, 0, ST_DATA);
    tab_add(RK_WORD, 0, 0, rev8(OP_SETRATE), 8'h00, 0, 0, 0, 0, ST_DATA);
    tab_add(RK_WORD, 0, 0, 8'hFF, 8'h00, 0, 0, 0, 0, ST_DATA);
    tab_add(RK_WORD, 0, 0, rev8(OP_RAND), 8'h3C, 0, 0, 0, 0, ST_DATA);
    // skip three bits: emission falls mid-word
    tab_add(RK_WORD, 0, 0, rev8(OP_SKIPBITS), 8'h00, 0, 0, 0, 0, ST_DATA);
    tab_add(RK_WORD, 0, 0, rev8(8'd3), 8'h00, 0, 0, 0, 0, ST_DATA);
    tab_add(RK_WORD, 0, 0, 8'hFF, 8'h00, 0, 0, 0, 0, ST_DATA);
    tab_add(RK_WORD, 0, 0, 8'h00, 8'h00, 0, 0, 0, 0, ST_DATA);
    // skip count beyond a byte drops the whole target
    tab_add(RK_WORD, 0, 0, rev8(OP_SKIPBITS), 8'h00, 0, 0, 0, 0, ST_DATA);
    tab_add(RK_WORD, 0, 0, 8'hFF, 8'h00, 0, 0, 0, 0, ST_DATA);
    tab_add(RK_WORD, 0, 0, 8'h5A, 8'h00, 0, 0, 0, 0, ST_DATA);
    tab_add(RK_WORD, 0, 0, 8'h96, 8'h00, 0, 0, 0, 0, ST_DATA);
    // invalid opcode halts the rest of the half
    tab_add(RK_WORD, 0, 0, rev8(8'hF5), 8'h00, 0, 0, 1, 8'h00, ST_BAD_OP);
    tab_add(RK_WORD, 0, 0, 8'h12, 8'h00, 0, 0, 0, 0, ST_DATA);
    // SETBITRATE in the last byte of a half
    tab_add(RK_WORD, 0, 0, rev8(OP_NOP), 8'h00, 1, 0, 0, 0, ST_DATA);
    tab_add(RK_NOPS, 0, 0, 0, 0, 0, 254, 0, 0, ST_DATA);
    tab_add(RK_WORD, 0, 0, rev8(OP_SETRATE), 8'h00, 0, 0, 1, 8'h00, ST_CUT_OP);
    // SKIPBITS count in the last byte
    tab_add(RK_WORD, 0, 0, rev8(OP_NOP), 8'h00, 1, 0, 0, 0, ST_DATA);
    tab_add(RK_NOPS, 0, 0, 0, 0, 0, 253, 0, 0, ST_DATA);
    tab_add(RK_WORD, 0, 0, rev8(OP_SKIPBITS), 8'h00, 0, 0, 0, 0, ST_DATA);
    tab_add(RK_WORD, 0, 0, rev8(8'd2), 8'h00, 0, 0, 1, 8'h00, ST_CUT_OP);
    // SKIPBITS itself in the last byte
    tab_add(RK_WORD, 0, 0, rev8(OP_NOP), 8'h00, 1, 0, 0, 0, ST_DATA);
    tab_add(RK_NOPS, 0, 0, 0, 0, 0, 254, 0, 0, ST_DATA);
    tab_add(RK_WORD, 0, 0, rev8(OP_SKIPBITS), 8'h00, 0, 0, 1, 8'h00, ST_CUT_OP);
    // ISO FM, then an encoding change mid-half with a partial byte pending
    tab_add(RK_CFG, CFG_ENC, ENC_ISO_FM, 0, 0, 0, 0, 0, 0, ST_DATA);
    tab_add(RK_WORD, 0, 0, 8'hFF, 8'h00, 1, 0, 0, 0, ST_DATA);
    tab_add(RK_WORD, 0, 0, 8'h00, 8'h00, 0, 0, 0, 0, ST_DATA);
    tab_add(RK_WORD, 0, 0, 8'hC3, 8'h00, 0, 0, 0, 0, ST_DATA);
    tab_add(RK_CFG, CFG_ENC, 8'hFF, 0, 0, 0, 0, 0, 0, ST_DATA);
    tab_add(RK_WORD, 0, 0, 8'h3C, 8'h00, 0, 0, 0, 0, ST_DATA);
    // second side: first half only moves the position
    tab_add(RK_CFG, CFG_SIDE, 8'h01, 0, 0, 0, 0, 0, 0, ST_DATA);
    tab_add(RK_WORD, 0, 0, 8'h55, 8'h00, 1, 0, 0, 0, ST_DATA);
    tab_add(RK_NOPS, 0, 0, 0, 0, 0, 255, 0, 0, ST_DATA);
    tab_add(RK_WORD, 0, 0, 8'h81, 8'h00, 0, 0, 0, 0, ST_DATA);
    tab_add(RK_CFG, CFG_ENC, 8'h01, 0, 0, 0, 0, 0, 0, ST_DATA);
    tab_add(RK_WORD, 0, 0, 8'h7E, 8'h00, 0, 0, 0, 0, ST_DATA);

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    foreach (dir_rows[i]) begin
      case (dir_rows[i].kind)
        RK_CFG: begin
          wait_drained();
          write_reg(dir_rows[i].idx, dir_rows[i].val);
        end
        RK_NOPS: begin
          for (int n = 0; n < dir_rows[i].reps; n++) begin
            send_word(rev8(OP_NOP), 8'h00, 1'b0, 1'b0, none);
          end
        end
        default: send_word(dir_rows[i].raw, dir_rows[i].fill, dir_rows[i].start,
                           dir_rows[i].typed, dir_rows[i].t_res);
      endcase
    end

    // Random phases: mostly well-formed opcode sequences with random content
    for (int p = 0; p < N_PHASES; p++) begin
      wait_drained();
      write_reg(CFG_V3, ph_v3[p][7:0]);
      write_reg(CFG_ENC, (p == N_PHASES - 1) ? 8'($urandom_range(255)) : ph_enc[p][7:0]);
      write_reg(CFG_SIDE, (p == N_PHASES - 1) ? 8'($urandom_range(1)) : ph_side[p][7:0]);
      case (ph_mode[p])
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 79; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 79; end
        default: begin send_idle_pct = 17; recv_stall_pct = 17; end
      endcase
      count_due = 1'b0;
      for (int k = 0; k < PHASE_WORDS; k++) begin
        if (p == 4 && k == 50) begin
          hold_asked++;           // receiver holds off while words keep coming
        end
        if (p == 1 && k == 60) begin
          wait_drained();         // sender pauses until all results are in
        end
        if (count_due) begin
          cnt = ($urandom_range(99) < 80) ? 8'($urandom_range(9)) : 8'($urandom_range(255));
          raw = rev8(cnt);
          count_due = 1'b0;
        end else begin
          sel = $urandom_range(99);
          if (sel < 50) begin
            raw = 8'($urandom_range(255));
            if (raw[3:0] == 4'hF) raw[0] = 1'b0;   // keep data clear of opcodes
          end else if (sel < 60) begin
            raw = $urandom_range(1) ? rev8(OP_NOP) : rev8(OP_SETINDEX);
          end else if (sel < 67) begin
            raw = rev8(OP_SETRATE);
          end else if (sel < 75) begin
            raw = rev8(OP_SKIPBITS);
            count_due = 1'b1;
          end else if (sel < 85) begin
            raw = rev8(OP_RAND);
          end else if (sel < 86) begin
            raw = rev8(8'($urandom_range(8'hFF, 8'hF5)));
          end else begin
            raw = 8'($urandom_range(255));
          end
        end
        send_word(raw, 8'($urandom_range(255)), ($urandom_range(299) == 0), 1'b0, none);
      end
    end

    send_idle_pct = 0;
    wait_drained();
    repeat (20) @(posedge clk);
    if (decoded_due.size() != 0) begin
      $display("%0t: %0d results never arrived", $time, decoded_due.size());
      errors++;
    end
    $display("%0d track words driven, %0d results checked over %0d random settings",
             words_sent, checked, N_PHASES);
    $display("covered: opcodes, cut-off operands, halts, FM gathering, both sides, stalls");
    if (errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

@@ hfe_track_bitstream_decoder_core.f @@
rtl/hfetbd_pkg.sv
rtl/hfetbd_front.sv
rtl/hfetbd_queue.sv
rtl/hfetbd_back.sv
rtl/hfe_track_bitstream_decoder_core.sv
test/hfe_track_bitstream_decoder_core_test.sv
